/* src/ccp_pkg.sv */
// Shared widths, status codes and stage payload types of the circle-through-three-points block.
package ccp_pkg;

  localparam int COORD_W = 32;               // input and center coordinates
  localparam int DIFF_W  = 33;               // difference of two coordinates
  localparam int SQ1_W   = 64;               // one squared difference
  localparam int SQ_W    = 65;               // sum of two squared differences
  localparam int LO_W    = 33;               // low slice of a squared length
  localparam int HI_W    = SQ_W - LO_W;      // high slice of a squared length
  localparam int DET_W   = 66;               // determinant of the two chords
  localparam int NUM_W   = 99;               // center numerator
  localparam int DVD_W   = NUM_W;            // divider dividend
  localparam int DEN_W   = DET_W;            // divider divisor
  localparam int QUO_W   = 41;               // quotient bits up to the offset cap
  localparam int ROOT_W  = 33;               // integer square root of SQ_W bits
  localparam int RAD_W   = 31;
  localparam int TOL_W   = 16;

  localparam int FRONT_LAT = 6;
  localparam int PLACE_LAT = QUO_W + 2;
  localparam int ROOT_LAT  = ROOT_W + 1;
  localparam int RAD_LAT   = 3 + ROOT_LAT;
  localparam int TOTAL_LAT = FRONT_LAT + PLACE_LAT + RAD_LAT;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_AXIS      = 2'd1,
    ST_COLLINEAR = 2'd2
  } status_t;

  // One rounded division request: base + round(num_signed / den_signed).
  typedef struct packed {
    logic                      valid;
    logic [DVD_W-1:0]          num;
    logic [DEN_W-1:0]          den;
    logic                      neg;
    logic signed [COORD_W-1:0] base;
  } div_req_t;

endpackage

/* src/circle_through_three_points.sv */
// Top level of the circle-through-three-points block: config register, pipeline and outputs.
//
// Usage: an item is three points in signed Q16.16, transferred at a rising edge where
// start is high and busy is low. busy never rises, so one item can be transferred
// every cycle. Each item gives exactly one result: out_valid is high for one cycle
// with center x, center y, radius and status on the out_ ports. Each item passes
// through 6 front stages (ordering choice, products, determinant, numerators, divider
// operands), 43 divider stages (one quotient bit each, plus the overflow check and the
// final placement) and 37 stages for the radius (difference, square, sum, 33 root
// digits and rounding). Items leave in the order they entered. Status 1 means every
// ordering has a chord on an axis, status 2 means collinear points; both give zero
// center and radius.
// The zero_tolerance register sits at byte address 0 of the APB-style port and may
// be written only while no item is in flight. Synchronous reset clears all valid
// bits and sets zero_tolerance to 0. The receiver has no way to hold results off and
// must take each one in its cycle.
module circle_through_three_points (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [ccp_pkg::COORD_W-1:0] in_first_x,
  input  logic signed [ccp_pkg::COORD_W-1:0] in_first_y,
  input  logic signed [ccp_pkg::COORD_W-1:0] in_second_x,
  input  logic signed [ccp_pkg::COORD_W-1:0] in_second_y,
  input  logic signed [ccp_pkg::COORD_W-1:0] in_third_x,
  input  logic signed [ccp_pkg::COORD_W-1:0] in_third_y,
  output logic                               out_valid,
  output logic signed [ccp_pkg::COORD_W-1:0] out_center_x,
  output logic signed [ccp_pkg::COORD_W-1:0] out_center_y,
  output logic [ccp_pkg::RAD_W-1:0]          out_radius,
  output logic [1:0]                         out_status,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import ccp_pkg::*;

  localparam logic REG_TOL = 1'b0;

  // Configuration port.
  logic [TOL_W-1:0] tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TOL) begin
      tol_r <= pwdata[TOL_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TOL) ? 32'(tol_r) : '0;
  assign busy   = 1'b0;

  // Front pipeline.
  div_req_t req_x, req_y;
  status_t  st_front;

  ccp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .tol         (tol_r),
    .in_valid    (start && !busy),
    .in_first_x  (in_first_x),
    .in_first_y  (in_first_y),
    .in_second_x (in_second_x),
    .in_second_y (in_second_y),
    .in_third_x  (in_third_x),
    .in_third_y  (in_third_y),
    .req_x       (req_x),
    .req_y       (req_y),
    .status      (st_front)
  );

  // Center coordinates.
  logic                      pl_valid;
  logic signed [COORD_W-1:0] cen_x, cen_y, base_x, base_y;
  logic [1:0]                st_place;

  ccp_place u_place_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req_x),
    .out_valid (pl_valid),
    .out_coord (cen_x),
    .out_base  (base_x)
  );

  ccp_place u_place_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req_y),
    .out_valid (),
    .out_coord (cen_y),
    .out_base  (base_y)
  );

  ccp_delay #(.WIDTH(2), .DEPTH(PLACE_LAT)) u_st_delay (
    .clk  (clk),
    .din  (st_front),
    .dout (st_place)
  );

  // Radius: distance from the first point of the chosen ordering to the saturated center.
  logic                       va_r, vb_r, vc_r;
  logic signed [DIFF_W-1:0]   dxa_r, dya_r;
  logic signed [2*DIFF_W-1:0] sq_x, sq_y;
  logic [SQ1_W-1:0]           sqxb_r, sqyb_r;
  logic [SQ_W-1:0]            sumc_r;

  always_comb begin
    sq_x = dxa_r * dxa_r;
    sq_y = dya_r * dya_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= pl_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    dxa_r  <= $signed({cen_x[COORD_W-1], cen_x}) - $signed({base_x[COORD_W-1], base_x});
    dya_r  <= $signed({cen_y[COORD_W-1], cen_y}) - $signed({base_y[COORD_W-1], base_y});
    sqxb_r <= sq_x[SQ1_W-1:0];
    sqyb_r <= sq_y[SQ1_W-1:0];
    sumc_r <= {1'b0, sqxb_r} + {1'b0, sqyb_r};
  end

  logic             rt_valid;
  logic [RAD_W-1:0] rt_root;

  ccp_root u_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vc_r),
    .in_sum    (sumc_r),
    .out_valid (rt_valid),
    .out_root  (rt_root)
  );

  logic signed [COORD_W-1:0] cen_x_d, cen_y_d;
  logic [1:0]                st_d;

  ccp_delay #(.WIDTH(2 * COORD_W + 2), .DEPTH(RAD_LAT)) u_cen_delay (
    .clk  (clk),
    .din  ({cen_x, cen_y, st_place}),
    .dout ({cen_x_d, cen_y_d, st_d})
  );

  // Anything but a found circle reports zero center and radius.
  logic found;

  assign found        = (status_t'(st_d) == ST_FOUND);
  assign out_valid    = rt_valid;
  assign out_status   = st_d;
  assign out_center_x = found ? cen_x_d : '0;
  assign out_center_y = found ? cen_y_d : '0;
  assign out_radius   = found ? rt_root : '0;

endmodule

/* src/ccp_delay.sv */
// Fixed-length shift line that keeps side data aligned with a pipeline.
module ccp_delay #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] pipe_r [DEPTH];

  always_ff @(posedge clk) begin
    pipe_r[0] <= din;
    for (int i = 1; i < DEPTH; i++) begin
      pipe_r[i] <= pipe_r[i-1];
    end
  end

  assign dout = pipe_r[DEPTH-1];

endmodule

/* src/ccp_front.sv */
// Front pipeline: ordering choice, chord products, determinant and center numerators.
module ccp_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [ccp_pkg::TOL_W-1:0]          tol,
  input  logic                               in_valid,
  input  logic signed [ccp_pkg::COORD_W-1:0] in_first_x,
  input  logic signed [ccp_pkg::COORD_W-1:0] in_first_y,
  input  logic signed [ccp_pkg::COORD_W-1:0] in_second_x,
  input  logic signed [ccp_pkg::COORD_W-1:0] in_second_y,
  input  logic signed [ccp_pkg::COORD_W-1:0] in_third_x,
  input  logic signed [ccp_pkg::COORD_W-1:0] in_third_y,
  output ccp_pkg::div_req_t                  req_x,
  output ccp_pkg::div_req_t                  req_y,
  output ccp_pkg::status_t                   status
);
  import ccp_pkg::*;

  localparam int NUM_ORD = 6;
  localparam int PL_W = LO_W + DIFF_W + 1;
  localparam int PH_W = HI_W + DIFF_W + 1;

  function automatic logic [5:0] ord_code(input logic [2:0] k);
    logic [5:0] c;
    case (k)
      3'd1:    c = {2'd0, 2'd2, 2'd1};
      3'd2:    c = {2'd1, 2'd0, 2'd2};
      3'd3:    c = {2'd1, 2'd2, 2'd0};
      3'd4:    c = {2'd2, 2'd1, 2'd0};
      3'd5:    c = {2'd2, 2'd0, 2'd1};
      default: c = {2'd0, 2'd1, 2'd2};
    endcase
    return c;
  endfunction

  function automatic logic signed [DIFF_W-1:0] diff(input logic signed [COORD_W-1:0] to,
                                                     input logic signed [COORD_W-1:0] from);
    return $signed({to[COORD_W-1], to}) - $signed({from[COORD_W-1], from});
  endfunction

  function automatic logic clear_of_zero(input logic signed [DIFF_W-1:0] d,
                                         input logic [TOL_W-1:0] t);
    logic [DIFF_W-1:0] m;
    m = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    return m > DIFF_W'(t);
  endfunction

  function automatic logic signed [NUM_W-1:0] wide_lo(input logic signed [PL_W-1:0] v);
    return {{(NUM_W-PL_W){v[PL_W-1]}}, v};
  endfunction

  function automatic logic signed [NUM_W-1:0] wide_hi(input logic signed [PH_W-1:0] v);
    logic signed [NUM_W-1:0] w;
    w = {{(NUM_W-PH_W){v[PH_W-1]}}, v};
    return w <<< LO_W;
  endfunction

  // Stage 1: pick the first ordering whose chords are clear of both axes.
  logic signed [COORD_W-1:0] px [3];
  logic signed [COORD_W-1:0] py [3];
  logic [5:0] code;
  logic [1:0] pa, pb, pc, sel_a, sel_b, sel_c;
  logic       hit;

  always_comb begin
    px[0] = in_first_x;  py[0] = in_first_y;
    px[1] = in_second_x; py[1] = in_second_y;
    px[2] = in_third_x;  py[2] = in_third_y;
  end

  always_comb begin
    hit   = 1'b0;
    sel_a = 2'd0;
    sel_b = 2'd0;
    sel_c = 2'd0;
    code  = '0;
    pa    = 2'd0;
    pb    = 2'd0;
    pc    = 2'd0;
    for (int k = NUM_ORD - 1; k >= 0; k--) begin
      code = ord_code(3'(k));
      pa = code[5:4];
      pb = code[3:2];
      pc = code[1:0];
      if (clear_of_zero(diff(py[pb], py[pa]), tol) && clear_of_zero(diff(py[pc], py[pb]), tol) &&
          clear_of_zero(diff(px[pb], px[pa]), tol) && clear_of_zero(diff(px[pc], px[pb]), tol)) begin
        hit   = 1'b1;
        sel_a = pa;
        sel_b = pb;
        sel_c = pc;
      end
    end
  end

  logic                      v1_r;
  status_t                   st1_r;
  logic signed [COORD_W-1:0] ax1_r, ay1_r;
  logic signed [DIFF_W-1:0]  bx1_r, by1_r, cx1_r, cy1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    st1_r <= hit ? ST_FOUND : ST_AXIS;
    ax1_r <= hit ? px[sel_a] : '0;
    ay1_r <= hit ? py[sel_a] : '0;
    bx1_r <= hit ? diff(px[sel_b], px[sel_a]) : '0;
    by1_r <= hit ? diff(py[sel_b], py[sel_a]) : '0;
    cx1_r <= hit ? diff(px[sel_c], px[sel_a]) : '0;
    cy1_r <= hit ? diff(py[sel_c], py[sel_a]) : '0;
  end

  // Stage 2: cross products and squares of the chords.
  logic signed [2*DIFF_W-1:0] p_bc, p_bycx, p_bb, p_yy, p_cc, p_zz;

  always_comb begin
    p_bc   = bx1_r * cy1_r;
    p_bycx = by1_r * cx1_r;
    p_bb   = bx1_r * bx1_r;
    p_yy   = by1_r * by1_r;
    p_cc   = cx1_r * cx1_r;
    p_zz   = cy1_r * cy1_r;
  end

  logic                       v2_r;
  status_t                    st2_r;
  logic signed [COORD_W-1:0]  ax2_r, ay2_r;
  logic signed [DIFF_W-1:0]   bx2_r, by2_r, cx2_r, cy2_r;
  logic signed [2*DIFF_W-1:0] pbc2_r, pby2_r;
  logic [SQ1_W-1:0]           sbx2_r, sby2_r, scx2_r, scy2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    st2_r  <= st1_r;
    ax2_r  <= ax1_r;
    ay2_r  <= ay1_r;
    bx2_r  <= bx1_r;
    by2_r  <= by1_r;
    cx2_r  <= cx1_r;
    cy2_r  <= cy1_r;
    pbc2_r <= p_bc;
    pby2_r <= p_bycx;
    sbx2_r <= p_bb[SQ1_W-1:0];
    sby2_r <= p_yy[SQ1_W-1:0];
    scx2_r <= p_cc[SQ1_W-1:0];
    scy2_r <= p_zz[SQ1_W-1:0];
  end

  // Stage 3: determinant and squared chord lengths. A zero determinant means collinear.
  logic                      v3_r;
  status_t                   st3_r;
  logic signed [COORD_W-1:0] ax3_r, ay3_r;
  logic signed [DIFF_W-1:0]  bx3_r, by3_r, cx3_r, cy3_r;
  logic signed [DET_W-1:0]   d3_r;
  logic [SQ_W-1:0]           lb3_r, lc3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    st3_r <= (st2_r == ST_FOUND && pbc2_r == pby2_r) ? ST_COLLINEAR : st2_r;
    ax3_r <= ax2_r;
    ay3_r <= ay2_r;
    bx3_r <= bx2_r;
    by3_r <= by2_r;
    cx3_r <= cx2_r;
    cy3_r <= cy2_r;
    d3_r  <= pbc2_r - pby2_r;
    lb3_r <= {1'b0, sbx2_r} + {1'b0, sby2_r};
    lc3_r <= {1'b0, scx2_r} + {1'b0, scy2_r};
  end

  // Stage 4: squared lengths times chord components, split into two slices each.
  logic signed [PL_W-1:0] pl_bcy, pl_cby, pl_cbx, pl_bcx;
  logic signed [PH_W-1:0] ph_bcy, ph_cby, ph_cbx, ph_bcx;

  always_comb begin
    pl_bcy = $signed({1'b0, lb3_r[LO_W-1:0]}) * cy3_r;
    pl_cby = $signed({1'b0, lc3_r[LO_W-1:0]}) * by3_r;
    pl_cbx = $signed({1'b0, lc3_r[LO_W-1:0]}) * bx3_r;
    pl_bcx = $signed({1'b0, lb3_r[LO_W-1:0]}) * cx3_r;
    ph_bcy = $signed({1'b0, lb3_r[SQ_W-1:LO_W]}) * cy3_r;
    ph_cby = $signed({1'b0, lc3_r[SQ_W-1:LO_W]}) * by3_r;
    ph_cbx = $signed({1'b0, lc3_r[SQ_W-1:LO_W]}) * bx3_r;
    ph_bcx = $signed({1'b0, lb3_r[SQ_W-1:LO_W]}) * cx3_r;
  end

  logic                      v4_r;
  status_t                   st4_r;
  logic signed [COORD_W-1:0] ax4_r, ay4_r;
  logic signed [DET_W-1:0]   d4_r;
  logic signed [PL_W-1:0]    pl_bcy4_r, pl_cby4_r, pl_cbx4_r, pl_bcx4_r;
  logic signed [PH_W-1:0]    ph_bcy4_r, ph_cby4_r, ph_cbx4_r, ph_bcx4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    st4_r     <= st3_r;
    ax4_r     <= ax3_r;
    ay4_r     <= ay3_r;
    d4_r      <= d3_r;
    pl_bcy4_r <= pl_bcy;
    pl_cby4_r <= pl_cby;
    pl_cbx4_r <= pl_cbx;
    pl_bcx4_r <= pl_bcx;
    ph_bcy4_r <= ph_bcy;
    ph_cby4_r <= ph_cby;
    ph_cbx4_r <= ph_cbx;
    ph_bcx4_r <= ph_bcx;
  end

  // Stage 5: center numerators nx = Lb*cy - Lc*by and ny = Lc*bx - Lb*cx.
  logic                      v5_r;
  status_t                   st5_r;
  logic signed [COORD_W-1:0] ax5_r, ay5_r;
  logic signed [DET_W-1:0]   d5_r;
  logic signed [NUM_W-1:0]   nx5_r, ny5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    st5_r <= st4_r;
    ax5_r <= ax4_r;
    ay5_r <= ay4_r;
    d5_r  <= d4_r;
    nx5_r <= wide_hi(ph_bcy4_r) + wide_lo(pl_bcy4_r) - wide_hi(ph_cby4_r) - wide_lo(pl_cby4_r);
    ny5_r <= wide_hi(ph_cbx4_r) + wide_lo(pl_cbx4_r) - wide_hi(ph_bcx4_r) - wide_lo(pl_bcx4_r);
  end

  // Stage 6: divider operands. round(n/(2D)) = floor((|n| + |D|) / (2|D|)) in magnitude.
  logic [NUM_W-1:0] mag_nx, mag_ny;
  logic [DET_W-1:0] mag_d;

  always_comb begin
    mag_nx = nx5_r[NUM_W-1] ? NUM_W'(-nx5_r) : NUM_W'(nx5_r);
    mag_ny = ny5_r[NUM_W-1] ? NUM_W'(-ny5_r) : NUM_W'(ny5_r);
    mag_d  = d5_r[DET_W-1] ? DET_W'(-d5_r) : DET_W'(d5_r);
  end

  logic                      v6_r;
  status_t                   st6_r;
  logic signed [COORD_W-1:0] ax6_r, ay6_r;
  logic [DVD_W-1:0]          numx6_r, numy6_r;
  logic [DEN_W-1:0]          den6_r;
  logic                      negx6_r, negy6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    st6_r   <= st5_r;
    ax6_r   <= ax5_r;
    ay6_r   <= ay5_r;
    numx6_r <= DVD_W'(mag_nx) + DVD_W'(mag_d);
    numy6_r <= DVD_W'(mag_ny) + DVD_W'(mag_d);
    den6_r  <= {mag_d[DET_W-2:0], 1'b0};
    negx6_r <= nx5_r[NUM_W-1] ^ d5_r[DET_W-1];
    negy6_r <= ny5_r[NUM_W-1] ^ d5_r[DET_W-1];
  end

  assign req_x  = '{valid: v6_r, num: numx6_r, den: den6_r, neg: negx6_r, base: ax6_r};
  assign req_y  = '{valid: v6_r, num: numy6_r, den: den6_r, neg: negy6_r, base: ay6_r};
  assign status = st6_r;

endmodule

/* src/ccp_place.sv */
// Pipelined restoring divider, one quotient bit per stage, that places one center coordinate.
module ccp_place (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ccp_pkg::div_req_t                  req,
  output logic                               out_valid,
  output logic signed [ccp_pkg::COORD_W-1:0] out_coord,
  output logic signed [ccp_pkg::COORD_W-1:0] out_base
);
  import ccp_pkg::*;

  localparam int SH_W  = DEN_W + QUO_W;
  localparam int NST   = QUO_W + 1;
  localparam int SUM_W = QUO_W + 2;
  localparam logic [QUO_W-1:0] Q_CAP = QUO_W'(1) << (QUO_W - 1);
  localparam logic signed [SUM_W-1:0] S_MAX =
    {{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] S_MIN =
    {{(SUM_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

  logic                      v_r    [NST];
  logic [DVD_W-1:0]          rem_r  [NST];
  logic [QUO_W-1:0]          q_r    [NST];
  logic [DEN_W-1:0]          den_r  [NST];
  logic                      neg_r  [NST];
  logic                      ovf_r  [NST];
  logic signed [COORD_W-1:0] base_r [NST];

  // First stage flags a quotient of 2^QUO_W or more; such an offset is capped anyway.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= req.num;
    q_r[0]    <= '0;
    den_r[0]  <= req.den;
    neg_r[0]  <= req.neg;
    base_r[0] <= req.base;
    ovf_r[0]  <= SH_W'(req.num) >= (SH_W'(req.den) << QUO_W);
  end

  for (genvar gi = 1; gi < NST; gi++) begin : g_bit
    localparam int B = QUO_W - gi;
    logic [SH_W-1:0] sh;
    logic            take;

    always_comb begin
      sh   = SH_W'(den_r[gi-1]) << B;
      take = SH_W'(rem_r[gi-1]) >= sh;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[gi] <= 1'b0;
      end else begin
        v_r[gi] <= v_r[gi-1];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[gi]  <= take ? DVD_W'(SH_W'(rem_r[gi-1]) - sh) : rem_r[gi-1];
      q_r[gi]    <= take ? (q_r[gi-1] | (QUO_W'(1) << B)) : q_r[gi-1];
      den_r[gi]  <= den_r[gi-1];
      neg_r[gi]  <= neg_r[gi-1];
      ovf_r[gi]  <= ovf_r[gi-1];
      base_r[gi] <= base_r[gi-1];
    end
  end

  // Cap the offset, apply the sign, add the base point and saturate.
  logic [QUO_W-1:0]          qc;
  logic signed [SUM_W-1:0]   off, sum;
  logic signed [COORD_W-1:0] coord;

  always_comb begin
    qc  = (ovf_r[NST-1] || q_r[NST-1] > Q_CAP) ? Q_CAP : q_r[NST-1];
    off = neg_r[NST-1] ? -$signed(SUM_W'(qc)) : $signed(SUM_W'(qc));
    sum = off + $signed({{(SUM_W-COORD_W){base_r[NST-1][COORD_W-1]}}, base_r[NST-1]});
    if (sum > S_MAX) begin
      coord = S_MAX[COORD_W-1:0];
    end else if (sum < S_MIN) begin
      coord = S_MIN[COORD_W-1:0];
    end else begin
      coord = sum[COORD_W-1:0];
    end
  end

  logic                      out_valid_r;
  logic signed [COORD_W-1:0] out_coord_r, out_base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    out_coord_r <= coord;
    out_base_r  <= base_r[NST-1];
  end

  assign out_valid = out_valid_r;
  assign out_coord = out_coord_r;
  assign out_base  = out_base_r;

endmodule

/* src/ccp_root.sv */
// Pipelined digit-by-digit square root with round-to-nearest and saturation to the radius width.
module ccp_root (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [ccp_pkg::SQ_W-1:0]      in_sum,
  output logic                          out_valid,
  output logic [ccp_pkg::RAD_W-1:0]     out_root
);
  import ccp_pkg::*;

  localparam int TR_W = 2 * ROOT_W + 1;

  logic              v_r   [ROOT_W];
  logic [SQ_W-1:0]   rem_r [ROOT_W];
  logic [ROOT_W-1:0] rt_r  [ROOT_W];

  // Each stage keeps rem = s - r*r and decides one root bit from the top down.
  for (genvar gi = 0; gi < ROOT_W; gi++) begin : g_digit
    localparam int B = ROOT_W - 1 - gi;
    logic              sv;
    logic [SQ_W-1:0]   srem;
    logic [ROOT_W-1:0] srt;
    logic [TR_W-1:0]   trial;
    logic              take;

    if (gi == 0) begin : g_head
      assign sv   = in_valid;
      assign srem = in_sum;
      assign srt  = '0;
    end else begin : g_body
      assign sv   = v_r[gi-1];
      assign srem = rem_r[gi-1];
      assign srt  = rt_r[gi-1];
    end

    always_comb begin
      trial = (TR_W'(srt) << (B + 1)) | (TR_W'(1) << (2 * B));
      take  = TR_W'(srem) >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[gi] <= 1'b0;
      end else begin
        v_r[gi] <= sv;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[gi] <= take ? SQ_W'(TR_W'(srem) - trial) : srem;
      rt_r[gi]  <= take ? (srt | (ROOT_W'(1) << B)) : srt;
    end
  end

  // Round up when s exceeds r*r + r, that is when the remainder exceeds r.
  logic [ROOT_W:0] rr;

  always_comb begin
    rr = (ROOT_W + 1)'(rt_r[ROOT_W-1]) +
         (ROOT_W + 1)'(rem_r[ROOT_W-1] > SQ_W'(rt_r[ROOT_W-1]));
  end

  logic             out_valid_r;
  logic [RAD_W-1:0] out_root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v_r[ROOT_W-1];
    end
  end

  always_ff @(posedge clk) begin
    out_root_r <= (|rr[ROOT_W:RAD_W]) ? {RAD_W{1'b1}} : rr[RAD_W-1:0];
  end

  assign out_valid = out_valid_r;
  assign out_root  = out_root_r;

endmodule

/* src/ccp_checker.sv */
// Port-level checks for the circle-through-three-points block and their bind.
module ccp_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               out_valid,
  input logic signed [ccp_pkg::COORD_W-1:0] out_center_x,
  input logic signed [ccp_pkg::COORD_W-1:0] out_center_y,
  input logic [ccp_pkg::RAD_W-1:0]          out_radius,
  input logic [1:0]                         out_status
);
  import ccp_pkg::*;

  // The block never pushes back on the input side.
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy went high");

  // Every result stems from a transfer exactly one pipeline latency earlier.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, TOTAL_LAT))
    else $error("result without a matching input transfer");

  // A failed fit reports an all-zero circle.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_FOUND) |->
      (out_center_x == '0 && out_center_y == '0 && out_radius == '0))
    else $error("nonzero circle reported with a failure status");

  // Reset drains the pipeline at once.
  a_reset_flush: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

endmodule

bind circle_through_three_points ccp_checker u_ccp_checker (.*);

/* bench/tb_top.sv */
// Self-checking testbench for circle_through_three_points: random and directed triples.
module tb_top;
  import ccp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ADDR_TOL  = 0;
  localparam int ADDR_NONE = 4;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic signed [31:0] x [3];
    logic signed [31:0] y [3];
  } triple_t;

  typedef struct {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [RAD_W-1:0]   radius;
    status_t            status;
  } circle_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_first_x = '0, in_first_y = '0, in_second_x = '0;
  logic signed [31:0] in_second_y = '0, in_third_x = '0, in_third_y = '0;
  logic out_valid;
  logic signed [31:0] out_center_x, out_center_y;
  logic [RAD_W-1:0] out_radius;
  logic [1:0] out_status;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  triple_t pending_triples [$];
  circle_t expected_circles [$];
  logic [15:0] tol_model = '0;
  int send_idle_pct = 0;
  int stall_count = 0;
  bit failed = 1'b0;

  circle_through_three_points i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_first_x(in_first_x), .in_first_y(in_first_y),
    .in_second_x(in_second_x), .in_second_y(in_second_y),
    .in_third_x(in_third_x), .in_third_y(in_third_y),
    .out_valid(out_valid), .out_center_x(out_center_x), .out_center_y(out_center_y),
    .out_radius(out_radius), .out_status(out_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  function automatic bit beyond_tol(longint d, logic [15:0] tol);
    return ((d < 0) ? -d : d) > longint'(tol);
  endfunction

  // base + round(num/den), half away from zero, offset capped at 2^40, then saturated.
  function automatic logic signed [31:0] place_coord(longint base,
      logic signed [199:0] num, logic signed [199:0] den);
    logic [199:0] an, ad, q;
    longint off, v;
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    q = (2 * an + ad) / (2 * ad);
    if (q > (200'(1) << 40)) q = 200'(1) << 40;
    off = longint'(q[63:0]);
    if ((num < 0) ^ (den < 0)) off = -off;
    v = base + off;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic circle_t solve_circle(triple_t t, logic [15:0] tol);
    int ord_a [6] = '{0, 0, 1, 1, 2, 2};
    int ord_b [6] = '{1, 2, 0, 2, 1, 0};
    int ord_c [6] = '{2, 1, 2, 0, 0, 1};
    longint px [3], py [3];
    logic signed [199:0] bx, by, cx, cy, det, lb, lc, nx, ny;
    logic signed [127:0] dx, dy;
    logic [127:0] sq, root, probe;
    longint cxo, cyo;
    int a, b, c;
    circle_t res;
    res.cx = '0; res.cy = '0; res.radius = '0; res.status = ST_AXIS;
    for (int i = 0; i < 3; i++) begin
      px[i] = t.x[i];
      py[i] = t.y[i];
    end
    for (int k = 0; k < 6; k++) begin
      a = ord_a[k]; b = ord_b[k]; c = ord_c[k];
      if (beyond_tol(py[b] - py[a], tol) && beyond_tol(py[c] - py[b], tol) &&
          beyond_tol(px[b] - px[a], tol) && beyond_tol(px[c] - px[b], tol)) begin
        bx = px[b] - px[a]; by = py[b] - py[a];
        cx = px[c] - px[a]; cy = py[c] - py[a];
        det = bx * cy - by * cx;
        if (det == 0) begin
          res.status = ST_COLLINEAR;
          break;
        end
        lb = bx * bx + by * by;
        lc = cx * cx + cy * cy;
        nx = lb * cy - lc * by;
        ny = lc * bx - lb * cx;
        cxo = place_coord(px[a], nx, 2 * det);
        cyo = place_coord(py[a], ny, 2 * det);
        dx = cxo - px[a];
        dy = cyo - py[a];
        sq = dx * dx + dy * dy;
        root = '0;
        for (int bitn = 35; bitn >= 0; bitn--) begin
          probe = root | (128'(1) << bitn);
          if (probe * probe <= sq) root = probe;
        end
        if (sq > root * root + root) root = root + 1;
        if (root > 128'h7FFF_FFFF) root = 128'h7FFF_FFFF;
        res.cx = cxo[31:0];
        res.cy = cyo[31:0];
        res.radius = root[RAD_W-1:0];
        res.status = ST_FOUND;
        break;
      end
    end
    return res;
  endfunction

  function automatic triple_t pack_triple(int ax, int ay, int bx, int by, int cx, int cy);
    triple_t t;
    t.x[0] = ax; t.y[0] = ay; t.x[1] = bx; t.y[1] = by; t.x[2] = cx; t.y[2] = cy;
    return t;
  endfunction

  function automatic int small_coord();
    return int'($urandom_range(2 * (1 << 20))) - (1 << 20);
  endfunction

  // Mostly well-behaved triples, plus collinear, axis-aligned and near-tolerance ones.
  function automatic triple_t random_triple(logic [15:0] tol);
    triple_t t;
    int kind, k, dxs, dys;
    kind = $urandom_range(9);
    for (int i = 0; i < 3; i++) begin
      t.x[i] = (kind < 3) ? $urandom : small_coord();
      t.y[i] = (kind < 3) ? $urandom : small_coord();
    end
    case (kind)
      6: begin
        k = int'($urandom_range(8)) - 4;
        dxs = int'($urandom_range(2000)) - 1000;
        dys = int'($urandom_range(2000)) - 1000;
        t.x[1] = t.x[0] + dxs; t.y[1] = t.y[0] + dys;
        t.x[2] = t.x[0] + k * dxs; t.y[2] = t.y[0] + k * dys;
      end
      7: begin
        if ($urandom_range(1)) t.x[$urandom_range(2)] = t.x[$urandom_range(2)];
        else t.y[$urandom_range(2)] = t.y[$urandom_range(2)];
      end
      8: begin
        t.x[1] = t.x[0] + int'(tol) + int'($urandom_range(2)) - 1;
        t.y[2] = t.y[1] - int'(tol) - int'($urandom_range(2)) + 1;
      end
      default: ;
    endcase
    return t;
  endfunction

  task automatic write_reg(int addr, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= addr[2:0]; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr == ADDR_TOL) tol_model = value[15:0];
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain_pipeline();
    while (pending_triples.size() != 0 || expected_circles.size() != 0) @(posedge clk);
    repeat (TOTAL_LAT + 10) @(posedge clk);
  endtask

  // Sender: one item per cycle unless it chooses to idle.
  always @(negedge clk) begin
    if (rst_n && pending_triples.size() != 0 &&
        int'($urandom_range(99)) >= send_idle_pct) begin
      start <= 1'b1;
      in_first_x <= pending_triples[0].x[0]; in_first_y <= pending_triples[0].y[0];
      in_second_x <= pending_triples[0].x[1]; in_second_y <= pending_triples[0].y[1];
      in_third_x <= pending_triples[0].x[2]; in_third_y <= pending_triples[0].y[2];
    end else begin
      start <= 1'b0;
    end
  end

  // Transfer capture, result check and watchdog.
  always @(posedge clk) begin
    circle_t want;
    if (rst_n) begin
      if (start && !busy) begin
        expected_circles.push_back(solve_circle(pending_triples[0], tol_model));
        void'(pending_triples.pop_front());
      end
      if (out_valid) begin
        if (expected_circles.size() == 0) begin
          $error("unexpected result with nothing pending");
          failed = 1'b1;
        end else begin
          want = expected_circles.pop_front();
          if (out_center_x !== want.cx) begin
            $error("center_x expected %0d actual %0d", want.cx, out_center_x);
            failed = 1'b1;
          end
          if (out_center_y !== want.cy) begin
            $error("center_y expected %0d actual %0d", want.cy, out_center_y);
            failed = 1'b1;
          end
          if (out_radius !== want.radius) begin
            $error("radius expected %0d actual %0d", want.radius, out_radius);
            failed = 1'b1;
          end
          if (out_status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, out_status);
            failed = 1'b1;
          end
        end
      end
      if ((start && !busy) || out_valid) stall_count <= 0;
      else stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("circle_through_three_points test failed");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] tol_steps [6];
    tol_steps = '{16'd0, 16'd65535, 16'd1, 16'd777, 16'd0, 16'($urandom)};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed triples at the default tolerance of zero.
    pending_triples.push_back(pack_triple(0, 0, 0, 0, 0, 0));
    pending_triples.push_back(pack_triple(0, 0, 65536, 65536, 131072, 131072));
    pending_triples.push_back(pack_triple(0, 0, 65536, 0, 0, 65536));
    pending_triples.push_back(pack_triple(0, 0, 65536, 65536, 131072, 0));
    pending_triples.push_back(pack_triple(-2147483647 - 1, -2147483647 - 1, 2147483647,
                                          2147483647, -2147483647 - 1, 2147483647));
    pending_triples.push_back(pack_triple(2147483647, -2147483647 - 1, -2147483647 - 1,
                                          2147483647, 2147483647, 2147483646));
    pending_triples.push_back(pack_triple(-2147483647 - 1, -2147483647 - 1, 2147483647,
                                          2147483647, 0, 1));
    pending_triples.push_back(pack_triple(0, 0, 1, 1, 3, 2));
    pending_triples.push_back(pack_triple(1, 5, 2, 5, 3, 5));
    pending_triples.push_back(pack_triple(7, 1, 7, 2, 7, 3));
    pending_triples.push_back(pack_triple(100, 200, 300, 200, 500, 900));
    pending_triples.push_back(pack_triple(-65536, 0, 65536, 0, 0, 65536));
    pending_triples.push_back(pack_triple(1, 1, 2, 2, 3, -1));
    pending_triples.push_back(pack_triple(-1, -1, -1, -1, 5, 9));
    pending_triples.push_back(pack_triple(0, 0, 1000000, 1, 2000000, 3));
    drain_pipeline();
    write_reg(ADDR_NONE, 32'hFFFF_FFFF);

    for (int phase = 0; phase < 6; phase++) begin
      write_reg(ADDR_TOL, {16'd0, tol_steps[phase]});
      case (phase % 3)
        0: send_idle_pct = 34;
        1: send_idle_pct = 54;
        default: send_idle_pct = 0;
      endcase
      if (tol_steps[phase] != 0) begin
        pending_triples.push_back(pack_triple(0, 0, int'(tol_steps[phase]), 5,
                                              -3, 2 * int'(tol_steps[phase]) + 1));
        pending_triples.push_back(pack_triple(0, 0, int'(tol_steps[phase]) + 1, 100000,
                                              200000, -int'(tol_steps[phase]) - 1));
      end
      for (int n = 0; n < 125; n++) pending_triples.push_back(random_triple(tol_steps[phase]));
      drain_pipeline();
    end

    if (!failed && expected_circles.size() == 0) begin
      $display("circle_through_three_points test passed");
    end else begin
      $display("circle_through_three_points test failed");
    end
    $finish;
  end

endmodule
